### hw/rtl/lprl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lprl_pkg;

  localparam int unsigned LPRL_ENTRIES = 16;
  localparam int unsigned ID_W         = 16;
  localparam int unsigned VPN_W        = 27;
  localparam int unsigned OCC_W        = 5;
  localparam int unsigned ENTRY_W      = ID_W + VPN_W;

  typedef enum logic [1:0] {
    MODE_TOUCH = 2'd0,
    MODE_EVICT = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRD,
    S_SCMP,
    S_MRD,
    S_MWR,
    S_APPEND,
    S_ERD,
    S_EOUT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [ID_W-1:0]  page_id;
    logic [VPN_W-1:0] virt_page_number;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ID_W-1:0]  victim_page;
    logic [VPN_W-1:0] victim_vpn;
    logic [OCC_W-1:0] occupancy;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [VPN_W-1:0] vpn;
  } entry_t;

endpackage

`default_nettype wire

### hw/rtl/lprl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lprl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/lprl_wrap.sv
`timescale 1ns / 1ps
`default_nettype none

module lprl_wrap #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic [$clog2(ENTRIES)-1:0] head_i,
  input  wire logic [$clog2(ENTRIES)-1:0] off_i,
  output      logic [$clog2(ENTRIES)-1:0] phys_o
);

  localparam int unsigned IW = $clog2(ENTRIES);

  logic [IW:0] sum;

  // ring position: head plus offset, folded once since both are below the depth
  always_comb begin
    sum = {1'b0, head_i} + {1'b0, off_i};
    if (sum >= (IW+1)'(ENTRIES)) begin
      sum = sum - (IW+1)'(ENTRIES);
    end
    phys_o = sum[IW-1:0];
  end

endmodule

`default_nettype wire

### hw/rtl/lru_page_replacement_list.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | signals                  | transaction
// ----------+--------------------------+---------------------------------------
// request   | start, busy, req_i       | taken at a clock edge with start high
//           |                          | and busy low
// response  | done_o, rsp_o            | one cycle wide strobe, always taken
//
// the list lives in a ring buffer held in one ram (page id and vpn per entry),
// with a head pointer marking the least recent page; every ram address goes
// through one shared head-plus-offset wrap unit
// touch: the search reads and compares one slot at a time, a hit then
// closes the gap by copying each younger slot down one place, and the page
// is written at the most recent end; a miss on a full list drops the page
// and reports status full
// evict passes through S_ERD and S_EOUT unless the list is empty; clear and the unused mode go straight to S_RESP
// busy goes high once a request is taken and stays high through the response cycle
// reset empties the list; ram contents need no clearing, only slots below
// the count are read
// the receiver cannot stall: the response shows for exactly one cycle

module lru_page_replacement_list
  import lprl_pkg::*;
#(
  parameter int unsigned ENTRIES = LPRL_ENTRIES
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output      logic busy,
  input  wire req_t req_i,
  output      logic done_o,
  output      rsp_t rsp_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  // sequencer and datapath registers
  state_e        state_q, state_d;
  req_t          req_q, req_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [IW-1:0] head_q, head_d;
  logic [1:0]    status_q, status_d;
  entry_t        victim_q, victim_d;

  // ram and address unit
  logic          ram_we;
  entry_t        ram_wdata;
  entry_t        ram_rdata;
  logic [IW-1:0] off;
  logic [IW-1:0] phys;

  // handshake, hit and comparisons against the count
  logic          accept;
  logic          hit;
  logic [CW:0]   idx_p1;
  logic [CW:0]   idx_p2;
  logic          more1;
  logic          more2;
  logic          full;
  logic          empty;

  assign accept = start && !busy;
  assign hit    = (ram_rdata.id == req_q.page_id);
  assign idx_p1 = {1'b0, idx_q} + (CW+1)'(1);
  assign idx_p2 = {1'b0, idx_q} + (CW+1)'(2);
  assign more1  = idx_p1 < {1'b0, count_q};
  assign more2  = idx_p2 < {1'b0, count_q};
  assign full   = count_q >= CW'(ENTRIES);
  assign empty  = count_q == '0;

  lprl_wrap #(
    .ENTRIES(ENTRIES)
  ) u_wrap (
    .head_i(head_q),
    .off_i (off),
    .phys_o(phys)
  );

  lprl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(phys),
    .wdata_i(ram_wdata),
    .raddr_i(phys),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_e'(req_i.mode))
            MODE_TOUCH: state_d = empty ? S_APPEND : S_SRD;
            MODE_EVICT: state_d = empty ? S_RESP : S_ERD;
            MODE_CLEAR: state_d = S_RESP;
            MODE_NOP:   state_d = S_RESP;
            default:    state_d = S_RESP;
          endcase
        end
      end
      S_SRD:    state_d = S_SCMP;
      S_SCMP: begin
        if (hit) begin
          state_d = more1 ? S_MRD : S_APPEND;
        end else begin
          state_d = more1 ? S_SRD : S_APPEND;
        end
      end
      S_MRD:    state_d = S_MWR;
      S_MWR:    state_d = more2 ? S_MRD : S_APPEND;
      S_APPEND: state_d = S_RESP;
      S_ERD:    state_d = S_EOUT;
      S_EOUT:   state_d = S_RESP;
      S_RESP:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer: ram access and offset into the ring
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = ram_rdata;
    off       = '0;
    unique case (state_q)
      S_SRD: off = idx_q[IW-1:0];
      S_MRD: off = idx_p1[IW-1:0];
      S_MWR: begin
        // copy the younger slot just read one place down
        off    = idx_q[IW-1:0];
        ram_we = 1'b1;
      end
      S_APPEND: begin
        off       = count_q[IW-1:0];
        ram_we    = !full;
        ram_wdata = '{id: req_q.page_id, vpn: req_q.virt_page_number};
      end
      S_ERD: off = '0;
      default: off = '0;
    endcase
  end

  // datapath updates
  always_comb begin
    req_d    = req_q;
    count_d  = count_q;
    idx_d    = idx_q;
    head_d   = head_q;
    status_d = status_q;
    victim_d = victim_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d    = req_i;
          idx_d    = '0;
          status_d = ST_OK;
          victim_d = '0;
          if (mode_e'(req_i.mode) == MODE_CLEAR) begin
            count_d = '0;
          end
          if (mode_e'(req_i.mode) == MODE_EVICT && empty) begin
            status_d = ST_EMPTY;
          end
        end
      end
      S_SCMP: begin
        if (hit) begin
          if (!more1) begin
            // hit on the youngest slot: nothing to move
            count_d = count_q - CW'(1);
          end
        end else begin
          idx_d = idx_p1[CW-1:0];
        end
      end
      S_MWR: begin
        idx_d = idx_p1[CW-1:0];
        if (!more2) begin
          count_d = count_q - CW'(1);
        end
      end
      S_APPEND: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      S_EOUT: begin
        victim_d = ram_rdata;
        count_d  = count_q - CW'(1);
        head_d   = (head_q == IW'(ENTRIES - 1)) ? '0 : head_q + IW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      head_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
      idx_q   <= idx_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    status_q <= status_d;
    victim_q <= victim_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESP);

  assign rsp_o = '{
    status:      status_q,
    victim_page: victim_q.id,
    victim_vpn:  victim_q.vpn,
    occupancy:   OCC_W'(count_q)
  };

  // the count never passes the list depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ENTRIES))
    else $error("entry count above depth");

  // an accepted transaction keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("not busy after accepted transaction");

  // after the response the block is free again
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("still busy after response");

  // a dropped touch is only reported on a full list
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_FULL) |-> (count_q == CW'(ENTRIES)))
    else $error("full status with free slots");

endmodule

`default_nettype wire
